FILE: src/i2cmra_pkg.sv
// ----------------------------------------------------------------------------
// i2cmra_pkg
// Shared types, codes and helpers for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SDA_LOW  = 2'd1;
  localparam logic [1:0] ST_SDA_HIGH = 2'd2;
  localparam logic [1:0] ST_NACK     = 2'd3;

  // Sequencer phases
  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
  localparam logic [PhaseW-1:0] PH_START     = 4'd1;
  localparam logic [PhaseW-1:0] PH_ADDR      = 4'd2;
  localparam logic [PhaseW-1:0] PH_ADDR_ACK  = 4'd3;
  localparam logic [PhaseW-1:0] PH_REG       = 4'd4;
  localparam logic [PhaseW-1:0] PH_REG_ACK   = 4'd5;
  localparam logic [PhaseW-1:0] PH_DATA      = 4'd6;
  localparam logic [PhaseW-1:0] PH_DATA_ACK  = 4'd7;
  localparam logic [PhaseW-1:0] PH_RSTART    = 4'd8;
  localparam logic [PhaseW-1:0] PH_ADDR2     = 4'd9;
  localparam logic [PhaseW-1:0] PH_ADDR2_ACK = 4'd10;
  localparam logic [PhaseW-1:0] PH_RECV      = 4'd11;
  localparam logic [PhaseW-1:0] PH_NOACK     = 4'd12;
  localparam logic [PhaseW-1:0] PH_STOP      = 4'd13;
  localparam logic [PhaseW-1:0] PH_WAIT      = 4'd14;

  // Reset value of the post-write idle wait
  localparam logic [15:0] PostWriteReset = 16'd167;

  // One request: a tick, optionally carrying a command
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // One result
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic [1:0] status;
  } res_t;

  // Phase that follows a completed phase
  function automatic logic [PhaseW-1:0] next_phase(input logic [PhaseW-1:0] ph,
                                                   input logic is_read);
    logic [PhaseW-1:0] nxt;
    unique case (ph)
      PH_START:     nxt = PH_ADDR;
      PH_ADDR:      nxt = PH_ADDR_ACK;
      PH_ADDR_ACK:  nxt = PH_REG;
      PH_REG:       nxt = PH_REG_ACK;
      PH_REG_ACK:   nxt = is_read ? PH_RSTART : PH_DATA;
      PH_DATA:      nxt = PH_DATA_ACK;
      PH_DATA_ACK:  nxt = PH_STOP;
      PH_RSTART:    nxt = PH_ADDR2;
      PH_ADDR2:     nxt = PH_ADDR2_ACK;
      PH_ADDR2_ACK: nxt = PH_RECV;
      PH_RECV:      nxt = PH_NOACK;
      PH_NOACK:     nxt = PH_STOP;
      default:      nxt = PH_IDLE;
    endcase
    return nxt;
  endfunction

  // Shift register contents on entry to a phase
  function automatic logic [7:0] load_shift(input logic [PhaseW-1:0] ph,
                                            input logic [7:0] slave,
                                            input logic [7:0] regb,
                                            input logic [7:0] data,
                                            input logic [7:0] cur);
    logic [7:0] sh;
    unique case (ph)
      PH_ADDR:  sh = slave;
      PH_REG:   sh = regb;
      PH_DATA:  sh = data;
      PH_ADDR2: sh = slave + 8'd1;
      PH_RECV:  sh = 8'd0;
      default:  sh = cur;
    endcase
    return sh;
  endfunction

endpackage

FILE: src/i2cmra_in_stage.sv
// ----------------------------------------------------------------------------
// i2cmra_in_stage
// Input register: holds one accepted request until the core consumes it.
// ----------------------------------------------------------------------------
module i2cmra_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cmra_pkg::item_t   item_i,
  input  logic                take_i,
  output logic                valid_o,
  output i2cmra_pkg::item_t   item_o
);
  import i2cmra_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // Free slot, or the held request leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/i2cmra_core.sv
// ----------------------------------------------------------------------------
// i2cmra_core
// Bus sequencer: transaction state and the one-tick step logic.
// ----------------------------------------------------------------------------
module i2cmra_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                step_i,
  input  i2cmra_pkg::item_t   item_i,
  output i2cmra_pkg::res_t    res_o
);
  import i2cmra_pkg::*;

  // Sequencer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [1:0]        qstep_q, qstep_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;
  logic [7:0]        shift_q, shift_d;
  logic              is_read_q, is_read_d;
  logic [7:0]        slave_q, slave_d;
  logic [7:0]        regb_q, regb_d;
  logic [7:0]        data_q, data_d;
  logic [15:0]       wait_q, wait_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic [1:0]        fail_q, fail_d;
  logic [15:0]       post_wr_q;

  logic              enter_en, fin;
  logic [PhaseW-1:0] enter_ph;
  logic [1:0]        fin_code;
  res_t              res;

  // One tick of the sequencer
  always_comb begin
    phase_d   = phase_q;
    qstep_d   = qstep_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    is_read_d = is_read_q;
    slave_d   = slave_q;
    regb_d    = regb_q;
    data_d    = data_q;
    wait_d    = wait_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    fail_d    = fail_q;
    enter_en  = 1'b0;
    enter_ph  = PH_IDLE;
    fin       = 1'b0;
    fin_code  = ST_OK;
    res       = '0;

    // Command while idle: latch fields, first tick runs in this request
    if (phase_q == PH_IDLE && (item_i.cmd == CMD_WRITE || item_i.cmd == CMD_READ)) begin
      slave_d   = item_i.slave_addr;
      regb_d    = item_i.reg_addr;
      data_d    = item_i.write_data;
      is_read_d = (item_i.cmd == CMD_READ);
      fail_d    = ST_OK;
      shift_d   = 8'd0;
      wait_d    = 16'd0;
      phase_d   = PH_START;
      qstep_d   = 2'd0;
      bit_cnt_d = 4'd0;
    end

    unique case (phase_d)
      PH_IDLE: begin
      end
      PH_START, PH_RSTART: begin
        if (qstep_d == 2'd0) begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end else begin
          sda_d = 1'b0;
        end
        // only the first start checks the bus
        if (phase_d == PH_START && qstep_d == 2'd0 && !item_i.sda_in) begin
          fin      = 1'b1;
          fin_code = ST_SDA_LOW;
        end else if (phase_d == PH_START && qstep_d == 2'd1 && item_i.sda_in) begin
          fin      = 1'b1;
          fin_code = ST_SDA_HIGH;
        end else if (qstep_d[1]) begin
          enter_en = 1'b1;
          enter_ph = next_phase(phase_d, is_read_d);
        end else begin
          qstep_d = qstep_d + 2'd1;
        end
      end
      PH_ADDR, PH_REG, PH_DATA, PH_ADDR2: begin
        if (qstep_d == 2'd0) begin
          scl_d = 1'b0;
        end else if (qstep_d == 2'd1) begin
          sda_d   = shift_d[7];
          shift_d = {shift_d[6:0], 1'b0};
        end else begin
          scl_d = 1'b1;
        end
        if (qstep_d[1]) begin
          qstep_d   = 2'd0;
          bit_cnt_d = bit_cnt_d + 4'd1;
          if (bit_cnt_d[3]) begin
            enter_en = 1'b1;
            enter_ph = next_phase(phase_d, is_read_d);
          end
        end else begin
          qstep_d = qstep_d + 2'd1;
        end
      end
      PH_ADDR_ACK, PH_REG_ACK, PH_DATA_ACK, PH_ADDR2_ACK, PH_NOACK: begin
        unique case (qstep_d)
          2'd0: scl_d = 1'b0;
          2'd1: sda_d = 1'b1;
          2'd2: begin
            scl_d = 1'b1;
            // only the first address ACK can abort
            if (phase_d == PH_ADDR_ACK && item_i.sda_in) begin
              fail_d = ST_NACK;
            end
          end
          default: scl_d = 1'b0;
        endcase
        if (qstep_d == 2'd3) begin
          enter_en = 1'b1;
          enter_ph = (fail_d != ST_OK) ? PH_STOP : next_phase(phase_d, is_read_d);
        end else begin
          qstep_d = qstep_d + 2'd1;
        end
      end
      PH_RECV: begin
        if (qstep_d == 2'd0) begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          qstep_d = 2'd1;
        end else begin
          scl_d     = 1'b1;
          shift_d   = {shift_d[6:0], item_i.sda_in};
          qstep_d   = 2'd0;
          bit_cnt_d = bit_cnt_d + 4'd1;
          if (bit_cnt_d[3]) begin
            enter_en = 1'b1;
            enter_ph = next_phase(phase_d, is_read_d);
          end
        end
      end
      PH_STOP: begin
        unique case (qstep_d)
          2'd0:    scl_d = 1'b0;
          2'd1:    sda_d = 1'b0;
          2'd2:    scl_d = 1'b1;
          default: sda_d = 1'b1;
        endcase
        if (qstep_d == 2'd3) begin
          if (fail_d == ST_OK && !is_read_d && post_wr_q != 16'd0) begin
            enter_en = 1'b1;
            enter_ph = PH_WAIT;
            wait_d   = post_wr_q;
          end else begin
            fin      = 1'b1;
            fin_code = fail_d;
          end
        end else begin
          qstep_d = qstep_d + 2'd1;
        end
      end
      PH_WAIT: begin
        if (wait_d != 16'd0) begin
          wait_d = wait_d - 16'd1;
        end
        if (wait_d == 16'd0) begin
          fin      = 1'b1;
          fin_code = ST_OK;
        end
      end
      default: begin
        enter_en = 1'b1;
        enter_ph = PH_IDLE;
      end
    endcase

    // Phase entry
    if (enter_en) begin
      shift_d   = load_shift(enter_ph, slave_d, regb_d, data_d, shift_d);
      phase_d   = enter_ph;
      qstep_d   = 2'd0;
      bit_cnt_d = 4'd0;
    end

    // End or abort of a transaction
    if (fin) begin
      res.done_res   = 1'b1;
      res.status     = fin_code;
      res.read_value = (fin_code == ST_OK && is_read_d) ? shift_d : 8'd0;
      phase_d        = PH_IDLE;
      qstep_d        = 2'd0;
      bit_cnt_d      = 4'd0;
    end

    res.scl_out  = scl_d;
    res.sda_out  = sda_d;
    res.busy_res = (phase_d != PH_IDLE);
  end

  assign res_o = res;

  // State registers, updated once per consumed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      qstep_q   <= 2'd0;
      bit_cnt_q <= 4'd0;
      shift_q   <= 8'd0;
      is_read_q <= 1'b0;
      slave_q   <= 8'd0;
      regb_q    <= 8'd0;
      data_q    <= 8'd0;
      wait_q    <= 16'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      fail_q    <= ST_OK;
    end else if (step_i) begin
      phase_q   <= phase_d;
      qstep_q   <= qstep_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      is_read_q <= is_read_d;
      slave_q   <= slave_d;
      regb_q    <= regb_d;
      data_q    <= data_d;
      wait_q    <= wait_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      fail_q    <= fail_d;
    end
  end

  // Post-write wait register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_wr_q <= PostWriteReset;
    end else if (cfg_we_i) begin
      post_wr_q <= cfg_data_i;
    end
  end

endmodule

FILE: src/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master for one-byte register writes and reads on open-drain lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): every request is one quarter-bit
//   tick carrying the sampled SDA level; cmd_i = write or read starts a
//   transaction when the master is idle and is ignored while busy.
//   Output channel (out_valid_o/out_ready_i): exactly one result per request
//   with the SCL/SDA drive levels, busy, a done pulse, read byte and status.
//   Path: an accepted request passes the input register, then the result
//   register, where its result appears. Throughput is one request per cycle
//   while out_ready_i stays high; the step logic computes a tick combinationally.
//   Stall: while out_ready_i is low the result holds, the input register
//   keeps one more request, and in_ready_o then drops until the result goes.
//   Reset: lines released, sequencer idle, post-write wait set to 167 ticks.
//   cfg_we_i/cfg_data_i write the post-write wait; write only while idle.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  slave_addr_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_value_o,
  output logic [1:0]  status_o
);
  import i2cmra_pkg::*;

  item_t in_item, st_item;
  logic  st_valid, step;
  res_t  core_res;
  res_t  res_q;
  logic  out_valid_q, out_valid_d;

  assign in_item.cmd        = cmd_i;
  assign in_item.slave_addr = slave_addr_i;
  assign in_item.reg_addr   = reg_addr_i;
  assign in_item.write_data = write_data_i;
  assign in_item.sda_in     = sda_in_i;

  // Consume the held request when the result register is free
  assign step = st_valid && (!out_valid_q || out_ready_i);

  i2cmra_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (step),
    .valid_o    (st_valid),
    .item_o     (st_item)
  );

  i2cmra_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .item_i     (st_item),
    .res_o      (core_res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_out_o    = res_q.scl_out;
  assign sda_out_o    = res_q.sda_out;
  assign busy_res_o   = res_q.busy_res;
  assign done_res_o   = res_q.done_res;
  assign read_value_o = res_q.read_value;
  assign status_o     = res_q.status;

  // A finished transaction leaves the master idle
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // Status and read byte only on the done tick
  a_status_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK || read_value_o != 8'd0) |-> done_res_o)
    else $error("status or read byte outside a done tick");

  // A new result is only produced from a held request
  a_result_from_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_valid |=> !(out_valid_o && !$past(out_valid_o)))
    else $error("result appeared without a request");

endmodule

FILE: tb/i2c_master_register_access_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_tb
// Drives quarter-bit tick requests into the I2C register access master while
// acting as the bus device: it answers the start checks, the address ACK and
// the read byte, and injects start faults, NACKs, commands while busy and
// undefined commands. A cycle-level predictor of the sequencer computes the
// line levels, busy, done, read byte and status for each tick request, and the
// monitor checks every result against it. Idle and stall bursts on both
// channels; the post-write wait takes its reset value, 0, 1, small random
// values and 65535.
// ----------------------------------------------------------------------------
module i2c_master_register_access_tb;
  import i2cmra_pkg::*;

  localparam logic [1:0] CmdUndef = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = CMD_TICK;
  logic [7:0]  slave_addr_i = '0;
  logic [7:0]  reg_addr_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        sda_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  read_value_o;
  logic [1:0]  status_o;

  i2c_master_register_access uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .slave_addr_i (slave_addr_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .sda_in_i     (sda_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_out_o    (scl_out_o),
    .sda_out_o    (sda_out_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Tick requests waiting to be sent, and bus results still due
  item_t tick_pending[$];
  res_t  results_due[$];
  item_t cur_item;
  int    queued_total = 0;
  int    err_count = 0;
  int    stall_odds = 8;   // 0: no idling
  int    send_gap = 0;
  int    hold_gap = 0;

  // --------------------------------------------------------------------------
  // Sequencer predictor
  // --------------------------------------------------------------------------
  logic [15:0] post_wait = PostWriteReset;
  logic [3:0]  ph = PH_IDLE;
  logic [1:0]  qstep = '0;
  logic [3:0]  nbits = '0;
  logic [7:0]  shreg = '0;
  logic        rd_mode = 1'b0;
  logic [7:0]  sv_slave = '0;
  logic [7:0]  sv_reg = '0;
  logic [7:0]  sv_data = '0;
  logic [15:0] wait_left = '0;
  logic        scl_lvl = 1'b1;
  logic        sda_lvl = 1'b1;
  logic [1:0]  abort_code = ST_OK;
  logic        fin_done;
  logic [1:0]  fin_status;
  logic [7:0]  fin_value;

  function automatic void goto_phase(input logic [3:0] p);
    ph = p;
    qstep = '0;
    nbits = '0;
    case (p)
      PH_ADDR:  shreg = sv_slave;
      PH_REG:   shreg = sv_reg;
      PH_DATA:  shreg = sv_data;
      PH_ADDR2: shreg = sv_slave + 8'd1;
      PH_RECV:  shreg = '0;
      default:  ;
    endcase
  endfunction

  function automatic void step_on();
    case (ph)
      PH_START:     goto_phase(PH_ADDR);
      PH_ADDR:      goto_phase(PH_ADDR_ACK);
      PH_ADDR_ACK:  goto_phase(PH_REG);
      PH_REG:       goto_phase(PH_REG_ACK);
      PH_REG_ACK:   goto_phase(rd_mode ? PH_RSTART : PH_DATA);
      PH_DATA:      goto_phase(PH_DATA_ACK);
      PH_DATA_ACK:  goto_phase(PH_STOP);
      PH_RSTART:    goto_phase(PH_ADDR2);
      PH_ADDR2:     goto_phase(PH_ADDR2_ACK);
      PH_ADDR2_ACK: goto_phase(PH_RECV);
      PH_RECV:      goto_phase(PH_NOACK);
      PH_NOACK:     goto_phase(PH_STOP);
      default:      goto_phase(PH_IDLE);
    endcase
  endfunction

  function automatic void end_xfer(input logic [1:0] st);
    fin_done = 1'b1;
    fin_status = st;
    fin_value = (st == ST_OK && rd_mode) ? shreg : 8'd0;
    goto_phase(PH_IDLE);
  endfunction

  // One quarter-bit tick: line changes, then the levels held over the delay
  function automatic res_t bus_tick(input item_t it);
    res_t r;
    logic [1:0] q;
    fin_done = 1'b0;
    fin_status = ST_OK;
    fin_value = '0;
    if (ph == PH_IDLE && (it.cmd == CMD_WRITE || it.cmd == CMD_READ)) begin
      sv_slave = it.slave_addr;
      sv_reg = it.reg_addr;
      sv_data = it.write_data;
      rd_mode = (it.cmd == CMD_READ);
      abort_code = ST_OK;
      shreg = '0;
      wait_left = '0;
      goto_phase(PH_START);
    end
    if (ph != PH_IDLE) begin
      q = qstep;
      case (ph)
        // start / repeated start; only the first start checks SDA
        PH_START, PH_RSTART: begin
          if (q == 2'd0) begin
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
          end else begin
            sda_lvl = 1'b0;
          end
          if (ph == PH_START && q == 2'd0 && !it.sda_in) end_xfer(ST_SDA_LOW);
          else if (ph == PH_START && q == 2'd1 && it.sda_in) end_xfer(ST_SDA_HIGH);
          else if (q >= 2'd2) step_on();
          else qstep = q + 2'd1;
        end
        // byte out, MSB first, three ticks per bit
        PH_ADDR, PH_REG, PH_DATA, PH_ADDR2: begin
          if (q == 2'd0) scl_lvl = 1'b0;
          else if (q == 2'd1) begin
            sda_lvl = shreg[7];
            shreg = {shreg[6:0], 1'b0};
          end else scl_lvl = 1'b1;
          if (q >= 2'd2) begin
            qstep = '0;
            nbits = nbits + 4'd1;
            if (nbits >= 4'd8) step_on();
          end else begin
            qstep = q + 2'd1;
          end
        end
        // ACK slots; only the first address ACK is judged
        PH_ADDR_ACK, PH_REG_ACK, PH_DATA_ACK, PH_ADDR2_ACK, PH_NOACK: begin
          if (q == 2'd0) scl_lvl = 1'b0;
          else if (q == 2'd1) sda_lvl = 1'b1;
          else if (q == 2'd2) begin
            scl_lvl = 1'b1;
            if (ph == PH_ADDR_ACK && it.sda_in) abort_code = ST_NACK;
          end else scl_lvl = 1'b0;
          if (q == 2'd3) begin
            if (abort_code != ST_OK) goto_phase(PH_STOP);
            else step_on();
          end else begin
            qstep = q + 2'd1;
          end
        end
        // byte in, two ticks per bit
        PH_RECV: begin
          if (q == 2'd0) begin
            scl_lvl = 1'b0;
            sda_lvl = 1'b1;
            qstep = 2'd1;
          end else begin
            scl_lvl = 1'b1;
            shreg = {shreg[6:0], it.sda_in};
            qstep = '0;
            nbits = nbits + 4'd1;
            if (nbits >= 4'd8) step_on();
          end
        end
        PH_STOP: begin
          if (q == 2'd0) scl_lvl = 1'b0;
          else if (q == 2'd1) sda_lvl = 1'b0;
          else if (q == 2'd2) scl_lvl = 1'b1;
          else sda_lvl = 1'b1;
          if (q == 2'd3) begin
            if (abort_code == ST_OK && !rd_mode && post_wait != 16'd0) begin
              goto_phase(PH_WAIT);
              wait_left = post_wait;
            end else begin
              end_xfer(abort_code);
            end
          end else begin
            qstep = q + 2'd1;
          end
        end
        PH_WAIT: begin
          if (wait_left != 16'd0) wait_left = wait_left - 16'd1;
          if (wait_left == 16'd0) end_xfer(ST_OK);
        end
        default: goto_phase(PH_IDLE);
      endcase
    end
    r.scl_out = scl_lvl;
    r.sda_out = sda_lvl;
    r.busy_res = (ph != PH_IDLE);
    r.done_res = fin_done;
    r.read_value = fin_value;
    r.status = fin_status;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic go;
    logic load;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i <= CMD_TICK;
      send_gap = 0;
    end else begin
      go = in_valid_i && in_ready_o;
      if (go) results_due.push_back(bus_tick(cur_item));
      if (!in_valid_i || go) begin
        load = 1'b0;
        if (send_gap > 0) send_gap--;
        else if (stall_odds != 0 && $urandom_range(stall_odds - 1) == 0)
          send_gap = $urandom_range(18);
        else load = (tick_pending.size() != 0);
        if (load) begin
          cur_item = tick_pending.pop_front();
          cmd_i <= cur_item.cmd;
          slave_addr_i <= cur_item.slave_addr;
          reg_addr_i <= cur_item.reg_addr;
          write_data_i <= cur_item.write_data;
          sda_in_i <= cur_item.sda_in;
        end
        in_valid_i <= load;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic match(input string nm, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    logic rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          err_count++;
          $display("%0t ns: result with none expected, expected none, actual %0h",
                   $time, {scl_out_o, sda_out_o, busy_res_o, done_res_o,
                           read_value_o, status_o});
        end else begin
          want = results_due.pop_front();
          match("scl_out", want.scl_out, scl_out_o);
          match("sda_out", want.sda_out, sda_out_o);
          match("busy_res", want.busy_res, busy_res_o);
          match("done_res", want.done_res, done_res_o);
          match("read_value", want.read_value, read_value_o);
          match("status", want.status, status_o);
        end
      end
      rdy = 1'b0;
      if (hold_gap > 0) hold_gap--;
      else if (stall_odds != 0 && $urandom_range(stall_odds - 1) == 0)
        hold_gap = $urandom_range(18);
      else rdy = 1'b1;
      out_ready_i <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push(input logic [1:0] c, input logic s);
    item_t it;
    it.cmd = c;
    it.slave_addr = 8'($urandom);
    it.reg_addr = 8'($urandom);
    it.write_data = 8'($urandom);
    it.sda_in = s;
    tick_pending.push_back(it);
    queued_total++;
  endtask

  // Command field on a tick inside a transaction: ignored by a busy master
  function automatic logic [1:0] busy_cmd(input bit noisy);
    if (!noisy || $urandom_range(3) != 0) return CMD_TICK;
    case ($urandom_range(2))
      0:       return CMD_WRITE;
      1:       return CMD_READ;
      default: return CmdUndef;
    endcase
  endfunction

  // Ticks whose SDA sample does not matter
  task automatic fill(input int n, input bit noisy);
    repeat (n) push(busy_cmd(noisy), 1'($urandom_range(1)));
  endtask

  // One transaction with the device answers; fault picks the abort status
  task automatic add_xfer(input logic [1:0] op, input logic [7:0] sl, input logic [7:0] rg,
                          input logic [7:0] dt, input logic [7:0] rx,
                          input logic [1:0] fault, input bit noisy);
    item_t it;
    it.cmd = op;
    it.slave_addr = sl;
    it.reg_addr = rg;
    it.write_data = dt;
    it.sda_in = (fault != ST_SDA_LOW);
    tick_pending.push_back(it);
    queued_total++;
    if (fault == ST_SDA_LOW) return;
    push(busy_cmd(noisy), fault == ST_SDA_HIGH);
    if (fault == ST_SDA_HIGH) return;
    fill(1 + 24 + 2, noisy);                    // start tail, address, ACK lead-in
    push(busy_cmd(noisy), fault == ST_NACK);    // address ACK sample
    fill(1, noisy);
    if (fault == ST_NACK) begin
      fill(4, noisy);                           // stop
      return;
    end
    fill(24 + 4, noisy);                        // register byte and ACK
    if (op == CMD_WRITE) begin
      fill(24 + 4 + 4 + int'(post_wait), noisy);
    end else begin
      fill(3 + 24 + 4, noisy);                  // repeated start, address+1, ACK
      for (int k = 7; k >= 0; k--) begin
        fill(1, noisy);
        push(busy_cmd(noisy), rx[k]);
      end
      fill(4 + 4, noisy);                       // NACK, stop
    end
  endtask

  // Random traffic: mostly well-formed transactions, some raw noise
  task automatic gen_traffic(input int n);
    int goal;
    logic [1:0] op;
    logic [1:0] fault;
    int r;
    goal = queued_total + n;
    while (queued_total < goal) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 30)) push(2'($urandom_range(3)), 1'($urandom_range(1)));
        fill(120 + int'(post_wait), 1'b0);      // let any started transaction end
      end else begin
        repeat ($urandom_range(3)) push($urandom_range(1) ? CMD_TICK : CmdUndef,
                                        1'($urandom_range(1)));
        op = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        r = $urandom_range(19);
        fault = (r == 0) ? ST_SDA_LOW : (r == 1) ? ST_SDA_HIGH :
                (r < 4) ? ST_NACK : ST_OK;
        add_xfer(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), fault,
                 1'($urandom_range(1)));
      end
    end
  endtask

  // Wait until all requests are sent and all results are back
  task automatic settle();
    do @(negedge clk_i);
    while (tick_pending.size() != 0 || in_valid_i || results_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Run the sequencer back to idle
  task automatic quiesce();
    settle();
    while (ph != PH_IDLE) begin
      fill(int'(wait_left) + 120, 1'b0);
      settle();
    end
  endtask

  task automatic set_wait(input logic [15:0] v);
    quiesce();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    post_wait = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed at the reset wait: field extremes, address wrap, undefined command
    stall_odds = 8;
    add_xfer(CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, ST_OK, 1'b0);
    add_xfer(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, ST_OK, 1'b0);
    push(CmdUndef, 1'b1);
    push(CmdUndef, 1'b0);
    add_xfer(CMD_READ, 8'hA4, 8'h3C, 8'h00, 8'h00, ST_OK, 1'b1);

    // zero post-write wait: every outcome, then no idling
    set_wait(16'd0);
    add_xfer(CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'h00, ST_OK, 1'b1);
    add_xfer(CMD_WRITE, 8'h68, 8'h6B, 8'h00, 8'h00, ST_SDA_LOW, 1'b0);
    add_xfer(CMD_READ, 8'h68, 8'h75, 8'h00, 8'h00, ST_SDA_HIGH, 1'b0);
    add_xfer(CMD_WRITE, 8'hD0, 8'h1B, 8'h18, 8'h00, ST_NACK, 1'b1);
    add_xfer(CMD_READ, 8'hD0, 8'h43, 8'h00, 8'h00, ST_NACK, 1'b0);
    push(CMD_TICK, 1'b0);
    stall_odds = 0;
    add_xfer(CMD_WRITE, 8'h3A, 8'h5C, 8'hA5, 8'h00, ST_OK, 1'b0);
    add_xfer(CMD_READ, 8'h3A, 8'h5C, 8'h00, 8'h5A, ST_OK, 1'b0);
    gen_traffic(120);

    // small random wait, heavy idling, with a full drain in the middle
    set_wait(16'($urandom_range(2, 24)));
    stall_odds = 4;
    gen_traffic(80);
    settle();
    gen_traffic(80);

    set_wait(16'd1);
    stall_odds = 10;
    gen_traffic(80);

    // longest wait: a read and an aborted write, no idling to the end
    set_wait(16'hFFFF);
    stall_odds = 0;
    add_xfer(CMD_READ, 8'($urandom), 8'($urandom), 8'h00, 8'($urandom), ST_OK, 1'b1);
    add_xfer(CMD_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'h00, ST_NACK, 1'b1);
    quiesce();
    repeat (8) @(posedge clk_i);

    if (err_count == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit
  initial begin
    #25_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
src/i2cmra_pkg.sv
src/i2cmra_in_stage.sv
src/i2cmra_core.sv
src/i2c_master_register_access.sv
tb/i2c_master_register_access_tb.sv
